FILE: rtl/core/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, constants and helper functions of the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  // Map geometry
  localparam int unsigned NUM_PAGES  = 1048576;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned MAP_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  // Field widths
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned PAGE_W     = 20;
  localparam int unsigned BOUND_W    = 21;
  localparam int unsigned BIT_W      = 6;
  localparam int unsigned WORD_NUM_W = BOUND_W - BIT_W;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 1;

  localparam logic [BOUND_W-1:0] NUM_PAGES_B = BOUND_W'(NUM_PAGES);
  localparam logic [WORD_AW-1:0] LAST_WORD   = WORD_AW'(MAP_WORDS - 1);

  // Register reset values
  localparam logic [ADDR_W-1:0]  MEM_TOP_RST      = '0;
  localparam logic [BOUND_W-1:0] RESERVED_LOW_RST = BOUND_W'(2048);
  localparam logic [BOUND_W-1:0] KERNEL_START_RST = BOUND_W'(3072);
  localparam logic [BOUND_W-1:0] USER_START_RST   = BOUND_W'(32'h4_0000);

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT        = 3'd0,
    CMD_ALLOC       = 3'd1,
    CMD_FREE        = 3'd2,
    CMD_FIND_LOW    = 3'd3,
    CMD_FIND_KERNEL = 3'd4,
    CMD_FIND_USER   = 3'd5
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEM_TOP      = 2'd0,
    REG_RESERVED_LOW = 2'd1,
    REG_KERNEL_START = 2'd2,
    REG_USER_START   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_SETUP,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic accept;
    logic sweep_clr;
    logic sweep_init;
    logic rmw_rd;
    logic rmw_wr;
    logic scan_start;
    logic scan_en;
    logic out_load;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic sweep_last;
    logic page_ok;
    logic region_empty;
    logic hit;
    logic miss;
    logic out_free;
  } dp_stat_t;

  // Bit b set when b < k
  function automatic logic [WORD_BITS-1:0] therm_lt(input logic [BIT_W-1:0] k);
    logic [WORD_BITS-1:0] m;
    for (int b = 0; b < WORD_BITS; b++) begin
      m[b] = (BIT_W'(b) < k);
    end
    return m;
  endfunction

  // Bit b set when b > k
  function automatic logic [WORD_BITS-1:0] therm_gt(input logic [BIT_W-1:0] k);
    logic [WORD_BITS-1:0] m;
    for (int b = 0; b < WORD_BITS; b++) begin
      m[b] = (BIT_W'(b) > k);
    end
    return m;
  endfunction

  // Lowest clear bit (word must hold at least one clear bit)
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!w[b]) idx = BIT_W'(b);
    end
    return idx;
  endfunction

  function automatic logic [BOUND_W-1:0] clamp_pages(input logic [BOUND_W-1:0] v);
    return (v > NUM_PAGES_B) ? NUM_PAGES_B : v;
  endfunction

endpackage

FILE: rtl/core/pba_ctrl.sv
// ----------------------------------------------------------------------------
// pba_ctrl
// Command sequencer: clear pass, init sweep, read-modify-write, scan, reply.
// ----------------------------------------------------------------------------
module pba_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic [pba_pkg::CMD_W-1:0]     cmd_i,
  output logic                          s_tready_o,
  input  pba_pkg::dp_stat_t             stat_i,
  output pba_pkg::dp_cmd_t              ctrl_o
);
  import pba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (stat_i.sweep_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_tvalid_i) begin
          unique case (cmd_i)
            CMD_INIT:                                   state_d = ST_INIT;
            CMD_ALLOC, CMD_FREE:                        state_d = ST_RMW_RD;
            CMD_FIND_LOW, CMD_FIND_KERNEL, CMD_FIND_USER: state_d = ST_SETUP;
            default:                                    state_d = ST_DONE;
          endcase
        end
      end
      ST_INIT:   if (stat_i.sweep_last) state_d = ST_DONE;
      ST_RMW_RD: state_d = stat_i.page_ok ? ST_RMW_WR : ST_DONE;
      ST_RMW_WR: state_d = ST_DONE;
      ST_SETUP:  state_d = stat_i.region_empty ? ST_DONE : ST_SCAN;
      ST_SCAN:   if (stat_i.hit || stat_i.miss) state_d = ST_DONE;
      ST_DONE:   if (stat_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o     = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR:  ctrl_o.sweep_clr = 1'b1;
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        ctrl_o.accept = s_tvalid_i;
      end
      ST_INIT:   ctrl_o.sweep_init = 1'b1;
      ST_RMW_RD: ctrl_o.rmw_rd = 1'b1;
      ST_RMW_WR: ctrl_o.rmw_wr = 1'b1;
      ST_SETUP:  ctrl_o.scan_start = !stat_i.region_empty;
      ST_SCAN:   ctrl_o.scan_en = 1'b1;
      ST_DONE:   ctrl_o.out_load = stat_i.out_free;
      default:   ctrl_o = '0;
    endcase
  end

endmodule

FILE: rtl/core/pba_datapath.sv
// ----------------------------------------------------------------------------
// pba_datapath
// Config registers, used-page map memory, sweep and scan counters, result
// and output registers.
// ----------------------------------------------------------------------------
module pba_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [pba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pba_pkg::ADDR_W-1:0]        cfg_data_i,
  input  logic [pba_pkg::CMD_W-1:0]         cmd_i,
  input  logic [pba_pkg::PAGE_W-1:0]        page_i,
  input  pba_pkg::dp_cmd_t                  ctrl_i,
  output pba_pkg::dp_stat_t                 stat_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              out_found_o,
  output logic [pba_pkg::PAGE_W-1:0]        out_page_o,
  output logic [pba_pkg::ADDR_W-1:0]        out_addr_o
);
  import pba_pkg::*;

  // ---------------- configuration ----------------
  logic [ADDR_W-1:0]  mem_top_q;
  logic [BOUND_W-1:0] rlow_q, kstart_q, ustart_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_top_q <= MEM_TOP_RST;
      rlow_q    <= RESERVED_LOW_RST;
      kstart_q  <= KERNEL_START_RST;
      ustart_q  <= USER_START_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MEM_TOP:      mem_top_q <= cfg_data_i;
        REG_RESERVED_LOW: rlow_q    <= cfg_data_i[BOUND_W-1:0];
        REG_KERNEL_START: kstart_q  <= cfg_data_i[BOUND_W-1:0];
        REG_USER_START:   ustart_q  <= cfg_data_i[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- latched command ----------------
  logic [CMD_W-1:0]  cmd_q;
  logic [PAGE_W-1:0] page_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q  <= cmd_i;
      page_q <= page_i;
    end
  end

  logic                   page_ok;
  logic [WORD_AW-1:0]     page_word;
  logic [BIT_W-1:0]       page_bit;

  assign page_ok   = {1'b0, page_q} < NUM_PAGES_B;
  assign page_word = WORD_NUM_W'(page_q[PAGE_W-1:BIT_W]) > WORD_NUM_W'(LAST_WORD) ?
                     '0 : page_q[BIT_W +: WORD_AW];
  assign page_bit  = page_q[BIT_W-1:0];

  // ---------------- search region ----------------
  logic [BOUND_W-1:0]    lo, hi, hi_m1;
  logic                  region_empty;
  logic [WORD_NUM_W-1:0] lo_w, hi_w;

  always_comb begin
    unique case (cmd_q)
      CMD_FIND_LOW: begin
        lo = '0;
        hi = clamp_pages(kstart_q);
      end
      CMD_FIND_KERNEL: begin
        lo = clamp_pages(kstart_q);
        hi = clamp_pages(ustart_q);
      end
      default: begin
        lo = clamp_pages(ustart_q);
        hi = NUM_PAGES_B;
      end
    endcase
  end

  assign region_empty = !(lo < hi);
  assign hi_m1        = hi - BOUND_W'(1);
  assign lo_w         = lo[BOUND_W-1:BIT_W];
  assign hi_w         = hi_m1[BOUND_W-1:BIT_W];

  // ---------------- sweep counter ----------------
  logic [WORD_AW-1:0] sweep_q;
  logic               sweep_last;

  assign sweep_last = (sweep_q == LAST_WORD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (ctrl_i.accept) begin
      sweep_q <= '0;
    end else if (ctrl_i.sweep_clr || ctrl_i.sweep_init) begin
      sweep_q <= sweep_last ? '0 : sweep_q + WORD_AW'(1);
    end
  end

  // Init word: pages below reserved_low or above mem_top/4096 are used
  logic [WORD_NUM_W-1:0] sw_w, rlow_w, top_w;
  logic [PAGE_W-1:0]     top_page;
  logic [WORD_BITS-1:0]  low_mask, top_mask, init_word;

  assign sw_w     = WORD_NUM_W'(sweep_q);
  assign top_page = mem_top_q[ADDR_W-1:PAGE_SHIFT];
  assign rlow_w   = rlow_q[BOUND_W-1:BIT_W];
  assign top_w    = WORD_NUM_W'(top_page[PAGE_W-1:BIT_W]);

  always_comb begin
    if (sw_w < rlow_w)       low_mask = '1;
    else if (sw_w == rlow_w) low_mask = therm_lt(rlow_q[BIT_W-1:0]);
    else                     low_mask = '0;
    if (sw_w > top_w)        top_mask = '1;
    else if (sw_w == top_w)  top_mask = therm_gt(top_page[BIT_W-1:0]);
    else                     top_mask = '0;
    init_word = low_mask | top_mask;
  end

  // ---------------- scan pipeline ----------------
  logic [WORD_AW-1:0]   rd_addr_q, rtag_q;
  logic                 issue_q, rvld_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic [WORD_BITS-1:0] masked, below_m, above_m;
  logic [BIT_W-1:0]     zero_bit;
  logic                 all_used, hit, miss;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      rvld_q  <= 1'b0;
    end else if (ctrl_i.scan_start) begin
      issue_q <= 1'b1;
      rvld_q  <= 1'b0;
    end else if (ctrl_i.scan_en && issue_q) begin
      rvld_q <= 1'b1;
      if (WORD_NUM_W'(rd_addr_q) == hi_w) issue_q <= 1'b0;
    end else begin
      issue_q <= 1'b0;
      rvld_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_start) begin
      rd_addr_q <= lo_w[WORD_AW-1:0];
    end else if (ctrl_i.scan_en && issue_q) begin
      rd_addr_q <= rd_addr_q + WORD_AW'(1);
      rtag_q    <= rd_addr_q;
    end
  end

  assign below_m  = (WORD_NUM_W'(rtag_q) == lo_w) ? therm_lt(lo[BIT_W-1:0]) : '0;
  assign above_m  = (WORD_NUM_W'(rtag_q) == hi_w) ? therm_gt(hi_m1[BIT_W-1:0]) : '0;
  assign masked   = rdata_q | below_m | above_m;
  assign all_used = &masked;
  assign zero_bit = first_zero(masked);
  assign hit      = ctrl_i.scan_en && rvld_q && !all_used;
  assign miss     = ctrl_i.scan_en && rvld_q && all_used &&
                    (WORD_NUM_W'(rtag_q) == hi_w);

  logic              hit_q;
  logic [PAGE_W-1:0] hit_page_q;
  logic [BOUND_W-1:0] hit_page_full;

  assign hit_page_full = {WORD_NUM_W'(rtag_q), zero_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           hit_q <= 1'b0;
    else if (ctrl_i.accept) hit_q <= 1'b0;
    else if (hit)          hit_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (hit) hit_page_q <= hit_page_full[PAGE_W-1:0];
  end

  // ---------------- map memory ----------------
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic                 we, re;
  logic [WORD_AW-1:0]   waddr, raddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] page_onehot, zero_onehot;

  assign page_onehot = WORD_BITS'(1) << page_bit;
  assign zero_onehot = WORD_BITS'(1) << zero_bit;

  always_comb begin
    we    = 1'b0;
    waddr = sweep_q;
    wdata = '0;
    if (ctrl_i.sweep_clr) begin
      we = 1'b1;
    end else if (ctrl_i.sweep_init) begin
      we    = 1'b1;
      wdata = init_word;
    end else if (ctrl_i.rmw_wr) begin
      we    = 1'b1;
      waddr = page_word;
      wdata = (cmd_q == CMD_ALLOC) ? (rdata_q | page_onehot) : (rdata_q & ~page_onehot);
    end else if (hit) begin
      we    = 1'b1;
      waddr = rtag_q;
      wdata = rdata_q | zero_onehot;
    end
  end

  assign re    = ctrl_i.rmw_rd || (ctrl_i.scan_en && issue_q);
  assign raddr = ctrl_i.rmw_rd ? page_word : rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (re) rdata_q <= mem[raddr];
  end

  // ---------------- result and output register ----------------
  logic              res_found;
  logic [PAGE_W-1:0] res_page;
  logic [ADDR_W-1:0] res_addr;

  always_comb begin
    res_found = 1'b0;
    res_page  = '0;
    res_addr  = '0;
    unique case (cmd_q)
      CMD_INIT: res_found = 1'b1;
      CMD_ALLOC: begin
        res_found = page_ok;
        res_page  = page_ok ? page_q : '0;
        res_addr  = page_ok ? ADDR_W'({page_q, {PAGE_SHIFT{1'b0}}}) : '0;
      end
      CMD_FREE: begin
        res_found = page_ok;
        res_page  = page_ok ? page_q : '0;
      end
      CMD_FIND_LOW, CMD_FIND_KERNEL, CMD_FIND_USER: begin
        res_found = hit_q;
        res_page  = hit_q ? hit_page_q : '0;
        res_addr  = hit_q ? ADDR_W'({hit_page_q, {PAGE_SHIFT{1'b0}}}) : '0;
      end
      default: ;
    endcase
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)             out_valid_q <= 1'b0;
    else if (ctrl_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i)     out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_found_o <= res_found;
      out_page_o  <= res_page;
      out_addr_o  <= res_addr;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o              = '0;
    stat_o.sweep_last   = sweep_last;
    stat_o.page_ok      = page_ok;
    stat_o.region_empty = region_empty;
    stat_o.hit          = hit;
    stat_o.miss         = miss;
    stat_o.out_free     = !out_valid_q || out_ready_i;
  end

endmodule

FILE: rtl/core/page_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator_unit
// First-fit page frame allocator over a one-bit-per-page used map.
// ----------------------------------------------------------------------------
// Usage:
//  - Command beats arrive on the s_* stream: s_tuser carries the command
//    (init, alloc, free, find low/kernel/user), s_tdata the page index.
//  - One reply beat per command leaves on m_*: m_tuser is the found flag,
//    m_tdata holds result page and byte address.
//  - Config registers are written on the cfg_* channel (always ready) while
//    no command is in flight; the user must ensure this, the block does not enforce it.
//  - After reset the map memory is cleared one 64-bit word per cycle, all
//    MAP_WORDS words (16384 at 1M pages), during which s_tready stays low.
//  - Steps from the accepted beat to m_tvalid, set by the single map
//    memory port and the word scan:
//      alloc/free    read, modify-write, reply; a page out of range skips the write
//      init          one word written per cycle over the whole map, then reply
//      find          setup, word scan up to the first free page, reply; if empty, setup and reply
//  - One command is processed at a time; the next beat is accepted as soon
//    as the reply sits in the output register, even while m_tready is low.
//    A stalled reply holds; the next reply waits until the first is taken.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pba_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pba_pkg::ADDR_W-1:0]         cfg_data_i,
  // Command stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pba_pkg::IN_DATA_W-1:0]      s_tdata,   // [19:0] page_index, [23:20] zero
  input  logic [pba_pkg::IN_USER_W-1:0]      s_tuser,   // [2:0] cmd
  // Reply stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pba_pkg::OUT_DATA_W-1:0]     m_tdata,   // [19:0] result_page,
                                                        // [51:20] page_address, [55:52] zero
  output logic [pba_pkg::OUT_USER_W-1:0]     m_tuser    // [0] found
);
  import pba_pkg::*;

  dp_cmd_t  ctrl;
  dp_stat_t stat;

  logic              out_found;
  logic [PAGE_W-1:0] out_page;
  logic [ADDR_W-1:0] out_addr;

  // Registers may be written any time the block is idle; no back-pressure.
  assign cfg_ready_o = 1'b1;

  pba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .cmd_i      (s_tuser[CMD_W-1:0]),
    .s_tready_o (s_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  pba_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (s_tuser[CMD_W-1:0]),
    .page_i      (s_tdata[PAGE_W-1:0]),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_ready_i (m_tready),
    .out_valid_o (m_tvalid),
    .out_found_o (out_found),
    .out_page_o  (out_page),
    .out_addr_o  (out_addr)
  );

  // Reply packing: page in the low bits, byte address above, zero padding
  assign m_tdata = OUT_DATA_W'({out_addr, out_page});
  assign m_tuser = out_found;

endmodule

FILE: rtl/core/pba_checker.sv
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks of the page bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pba_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [pba_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input logic [pba_pkg::ADDR_W-1:0]         cfg_data_i,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [pba_pkg::IN_DATA_W-1:0]      s_tdata,
  input logic [pba_pkg::IN_USER_W-1:0]      s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [pba_pkg::OUT_DATA_W-1:0]     m_tdata,
  input logic [pba_pkg::OUT_USER_W-1:0]     m_tuser
);

  // A reply that is not taken holds its beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("reply changed while stalled");

  // One command at a time: accepting a beat closes the input
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command accepted while busy");

  // A failed command reports all zeros
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser[0] == 1'b0) |-> (m_tdata == '0))
    else $error("failed reply carries data");

  // Address is either zero or the page number times the page size
  a_addr_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[51:20] == '0) ||
                 ((m_tdata[51:32] == m_tdata[19:0]) && (m_tdata[31:20] == '0)))
    else $error("page address does not match result page");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (.*);
